// ===== rtl/lenorm_pkg.sv =====
// shared types and constants for the laplacian edge normalizer
package lenorm_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_A,
      ST_LD_B,
      ST_RD_MEM,
      ST_RD_DIV,
      ST_OUT
   } state_type;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_MAXVAL = 2'd2;
   localparam logic [1:0] CSR_INVERT = 2'd3;

   localparam int PIX_W  = 8;
   localparam int MAG_W  = 10;
   localparam int PROD_W = MAG_W + PIX_W;
   localparam int SUM_W  = 12;
   localparam int CSR_DATA_W = 9;

endpackage

// ===== rtl/lenorm_ram.sv =====
// generic simple dual port ram with registered read
module lenorm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/laplacian_edge_normalize.sv =====
// top level: laplacian edge magnitude with peak normalization
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_type, req_pixel
//  rsp     | out       | rsp_valid/rsp_stall | rsp_out_pixel, rsp_last, rsp_not_ready
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
//  a load reads the column ram twice, then computes and writes back
//  a read: magnitude ram read, multiply, 8 steps of the divider, output
//  an early read goes straight to the output; a load after the frame is complete is ignored
//  reset is synchronous; the magnitude ram needs no clearing, border pixels read as zero (maxval when inverted)
//  a stalled result waits in the output register and holds the next read in its output state
module laplacian_edge_normalize #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [lenorm_pkg::PIX_W-1:0]      req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lenorm_pkg::PIX_W-1:0]      rsp_out_pixel,
   output logic                              rsp_last,
   output logic                              rsp_not_ready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [lenorm_pkg::CSR_DATA_W-1:0] csr_data
);
   import lenorm_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int DH    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [PIX_W-1:0]      maxval_ff, maxval_in;
   logic                  invert_ff, invert_in;

   logic [CW-1:0]    load_col_ff, load_col_in;
   logic [RW-1:0]    load_row_ff, load_row_in;
   logic [AW-1:0]    load_lin_ff, load_lin_in;
   logic [CW-1:0]    read_col_ff, read_col_in;
   logic [RW-1:0]    read_row_ff, read_row_in;
   logic [AW-1:0]    read_lin_ff, read_lin_in;
   logic             loaded_ff, loaded_in;
   logic [MAG_W-1:0] peak_ff, peak_in;

   logic [PIX_W-1:0]   px_ff, px_in, left_ff, left_in;
   logic [2*PIX_W-1:0] cur_ff, cur_in;

   logic [MAG_W-1:0]  div_ff, div_in;
   logic [PIX_W-1:0]  mv_ff, mv_in;
   logic              inv_ff, inv_in, border_ff, border_in;
   logic              last_ff, last_in, nr_ff, nr_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PIX_W-1:0]  quo_ff, quo_in;
   logic [2:0]        step_ff, step_in;

   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic             rsp_nr_ff, rsp_nr_in;
   logic [PIX_W-1:0] rsp_pix_ff, rsp_pix_in;

   logic [DW-1:0] w_eff, col_p1, rcol_p1;
   logic [DH-1:0] h_eff, row_p1, rrow_p1;
   logic          req_acc, csr_wr, restart, out_free, interior;
   logic [SUM_W-1:0]  sum;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W-1:0] dsh;
   logic [PIX_W-1:0]  val;

   logic              line_we;
   logic [CW-1:0]     line_rd_addr;
   logic [2*PIX_W-1:0] line_rd_data;
   logic              mag_we;
   logic [AW-1:0]     mag_wr_addr;
   logic [MAG_W-1:0]  mag_rd_data;

   lenorm_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (load_col_ff),
      .wr_data ({cur_ff[PIX_W-1:0], px_ff}),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   lenorm_ram #(.WIDTH(MAG_W), .DEPTH(DEPTH)) u_mag_ram (
      .clock   (clock),
      .wr_en   (mag_we),
      .wr_addr (mag_wr_addr),
      .wr_data (mag),
      .rd_addr (read_lin_ff),
      .rd_data (mag_rd_data)
   );

   // clamped frame size
   always_comb begin
      if (width_ff < CSR_DATA_W'(3)) begin
         w_eff = DW'(3);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(width_ff);
      end
      if (height_ff < CSR_DATA_W'(3)) begin
         h_eff = DH'(3);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = DH'(MAX_HEIGHT);
      end else begin
         h_eff = DH'(height_ff);
      end
   end

   assign col_p1  = DW'(load_col_ff) + DW'(1);
   assign row_p1  = DH'(load_row_ff) + DH'(1);
   assign rcol_p1 = DW'(read_col_ff) + DW'(1);
   assign rrow_p1 = DH'(read_row_ff) + DH'(1);

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign interior = (32'(load_row_ff) >= 2) && (load_col_ff != '0) && (col_p1 < w_eff);
   assign sum = SUM_W'(cur_ff[2*PIX_W-1:PIX_W]) + SUM_W'(left_ff)
              + SUM_W'(line_rd_data[PIX_W-1:0]) + SUM_W'(px_ff)
              - {2'b00, cur_ff[PIX_W-1:0], 2'b00};
   assign mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

   assign line_rd_addr = (state_ff == ST_LD_A) ? load_col_ff + CW'(1) : load_col_ff;
   assign line_we      = (state_ff == ST_LD_B);
   assign mag_we       = (state_ff == ST_LD_B) && interior;
   assign mag_wr_addr  = load_lin_ff - AW'(w_eff);

   assign dsh = PROD_W'(div_ff) << step_ff;

   always_comb begin
      if (nr_ff || div_ff == '0) begin
         val = '0;
      end else begin
         val = quo_ff;
      end
      if (inv_ff && !nr_ff) begin
         val = mv_ff - val;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_type == REQ_READ) begin
                  state_in = loaded_ff ? ST_RD_MEM : ST_OUT;
               end else if (!loaded_ff) begin
                  state_in = ST_LD_A;
               end
            end
         end
         ST_LD_A:   state_in = ST_LD_B;
         ST_LD_B:   state_in = ST_IDLE;
         ST_RD_MEM: state_in = ST_RD_DIV;
         ST_RD_DIV: state_in = (step_ff == '0) ? ST_OUT : ST_RD_DIV;
         ST_OUT:    state_in = out_free ? ST_IDLE : ST_OUT;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and counters
   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      maxval_in = maxval_ff;
      invert_in = invert_ff;
      load_col_in = load_col_ff;
      load_row_in = load_row_ff;
      load_lin_in = load_lin_ff;
      read_col_in = read_col_ff;
      read_row_in = read_row_ff;
      read_lin_in = read_lin_ff;
      loaded_in = loaded_ff;
      peak_in = peak_ff;
      px_in = px_ff;
      left_in = left_ff;
      cur_in = cur_ff;
      div_in = div_ff;
      mv_in = mv_ff;
      inv_in = inv_ff;
      border_in = border_ff;
      last_in = last_ff;
      nr_in = nr_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in = rsp_pix_ff;
      rsp_last_in = rsp_last_ff;
      rsp_nr_in = rsp_nr_ff;
      restart = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               px_in = req_pixel;
               mv_in = maxval_ff;
               inv_in = invert_ff;
               div_in = peak_ff;
               nr_in = !loaded_ff;
               border_in = (read_row_ff == '0) || (rrow_p1 == h_eff)
                        || (read_col_ff == '0) || (rcol_p1 == w_eff);
               last_in = (rrow_p1 == h_eff) && (rcol_p1 == w_eff);
               if (req_type == REQ_READ && loaded_ff) begin
                  if ((rrow_p1 == h_eff) && (rcol_p1 == w_eff)) begin
                     restart = 1'b1;
                  end else begin
                     read_lin_in = read_lin_ff + AW'(1);
                     if (rcol_p1 == w_eff) begin
                        read_col_in = '0;
                        read_row_in = read_row_ff + RW'(1);
                     end else begin
                        read_col_in = read_col_ff + CW'(1);
                     end
                  end
               end
            end
         end
         ST_LD_A: cur_in = line_rd_data;
         ST_LD_B: begin
            left_in = cur_ff[PIX_W-1:0];
            if (interior && mag > peak_ff) begin
               peak_in = mag;
            end
            load_lin_in = load_lin_ff + AW'(1);
            if (col_p1 == w_eff) begin
               load_col_in = '0;
               if (row_p1 == h_eff) begin
                  load_row_in = '0;
                  load_lin_in = '0;
                  loaded_in = 1'b1;
               end else begin
                  load_row_in = load_row_ff + RW'(1);
               end
            end else begin
               load_col_in = load_col_ff + CW'(1);
            end
         end
         ST_RD_MEM: begin
            rem_in = border_ff ? '0 : PROD_W'(mag_rd_data) * PROD_W'(mv_ff);
            quo_in = '0;
            step_in = 3'd7;
         end
         ST_RD_DIV: begin
            if (rem_ff >= dsh) begin
               rem_in = rem_ff - dsh;
               quo_in[step_ff] = 1'b1;
            end
            step_in = step_ff - 3'd1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in = val;
               rsp_last_in = last_ff && !nr_ff;
               rsp_nr_in = nr_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_wr) begin
         case (csr_index)
            CSR_WIDTH: begin
               width_in = csr_data;
               restart = 1'b1;
            end
            CSR_HEIGHT: begin
               height_in = csr_data;
               restart = 1'b1;
            end
            CSR_MAXVAL: maxval_in = csr_data[PIX_W-1:0];
            CSR_INVERT: invert_in = csr_data[0];
            default: begin
            end
         endcase
      end

      if (restart) begin
         peak_in = '0;
         load_col_in = '0;
         load_row_in = '0;
         load_lin_in = '0;
         read_col_in = '0;
         read_row_in = '0;
         read_lin_in = '0;
         loaded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         width_ff <= CSR_DATA_W'(256);
         height_ff <= CSR_DATA_W'(256);
         maxval_ff <= PIX_W'(255);
         invert_ff <= 1'b0;
         load_col_ff <= '0;
         load_row_ff <= '0;
         load_lin_ff <= '0;
         read_col_ff <= '0;
         read_row_ff <= '0;
         read_lin_ff <= '0;
         loaded_ff <= 1'b0;
         peak_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         maxval_ff <= maxval_in;
         invert_ff <= invert_in;
         load_col_ff <= load_col_in;
         load_row_ff <= load_row_in;
         load_lin_ff <= load_lin_in;
         read_col_ff <= read_col_in;
         read_row_ff <= read_row_in;
         read_lin_ff <= read_lin_in;
         loaded_ff <= loaded_in;
         peak_ff <= peak_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      cur_ff <= cur_in;
      div_ff <= div_in;
      mv_ff <= mv_in;
      inv_ff <= inv_in;
      border_ff <= border_in;
      last_ff <= last_in;
      nr_ff <= nr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      step_ff <= step_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
      rsp_nr_ff <= rsp_nr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pix_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_not_ready = rsp_nr_ff;

endmodule

// ===== rtl/lenorm_chk.sv =====
// port checker for the laplacian edge normalizer, bound to the top level
module lenorm_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              req_type,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [lenorm_pkg::PIX_W-1:0]      rsp_out_pixel,
   input logic                              rsp_last,
   input logic                              rsp_not_ready
);
   import lenorm_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_nr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_ready |-> rsp_out_pixel == '0 && !rsp_last)
      else $error("early read item carries data");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_READ |=> req_stall)
      else $error("read item did not hold off the next item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_pixel)
         && $stable(rsp_last) && $stable(rsp_not_ready))
      else $error("stalled result changed");

endmodule

bind laplacian_edge_normalize lenorm_chk u_lenorm_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_pixel (rsp_out_pixel),
   .rsp_last      (rsp_last),
   .rsp_not_ready (rsp_not_ready)
);

// ===== tb/sv/laplacian_edge_normalize_tb.sv =====
// testbench for the laplacian edge normalizer: directed and random frames, checked by a predictor
`timescale 1ns / 1ps

module laplacian_edge_normalize_tb;
   import lenorm_pkg::*;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic       last;
      logic       not_ready;
   } edge_rsp_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_type;
   logic [7:0] req_pixel;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_pixel;
   logic       rsp_last;
   logic       rsp_not_ready;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [8:0] csr_data;

   laplacian_edge_normalize dut (.*);

   // predictor state
   logic [7:0] row_pixels [512];
   logic [9:0] mag_mem [65536];
   int         peak;
   int         ld_row;
   int         ld_col;
   int         rd_idx;
   bit         loaded;
   logic [8:0] cfg_width;
   logic [8:0] cfg_height;
   logic [7:0] cfg_maxval;
   logic       cfg_invert;

   edge_rsp_type pending_pixels [$];
   int         errors;
   int         checked;
   int         loads_sent;
   int         reads_sent;
   int         send_idle_pct;
   int         stall_pct;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("laplacian_edge_normalize_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic int clamp_size(logic [8:0] v);
      if (v < 3) return 3;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic void restart_frame();
      peak = 0;
      ld_row = 0;
      ld_col = 0;
      rd_idx = 0;
      loaded = 1'b0;
   endfunction

   function automatic void edge_load(logic [7:0] px);
      int w, h, cur, prv, sum, mag;
      w = clamp_size(cfg_width);
      h = clamp_size(cfg_height);
      if (loaded) return;
      cur = (ld_row % 2) * 256;
      prv = ((ld_row + 1) % 2) * 256;
      if (ld_row == 0 || ld_row == h - 1 || ld_col == 0 || ld_col == w - 1)
         mag_mem[ld_row * w + ld_col] = '0;
      if (ld_row >= 2 && ld_col >= 1 && ld_col + 1 < w) begin
         sum = int'(row_pixels[cur + ld_col]) + int'(row_pixels[prv + ld_col - 1])
             + int'(row_pixels[prv + ld_col + 1]) + int'(px)
             - 4 * int'(row_pixels[prv + ld_col]);
         mag = (sum < 0) ? -sum : sum;
         mag_mem[(ld_row - 1) * w + ld_col] = mag[9:0];
         if (mag > peak) peak = mag;
      end
      row_pixels[cur + ld_col] = px;
      if (ld_col + 1 < w) begin
         ld_col++;
      end else begin
         ld_col = 0;
         if (ld_row + 1 < h) begin
            ld_row++;
         end else begin
            ld_row = 0;
            loaded = 1'b1;
         end
      end
   endfunction

   function automatic edge_rsp_type edge_read();
      edge_rsp_type r;
      int total, val;
      total = clamp_size(cfg_width) * clamp_size(cfg_height);
      r = '0;
      if (!loaded) begin
         r.not_ready = 1'b1;
         return r;
      end
      if (rd_idx >= total) rd_idx = 0;
      val = 0;
      if (peak != 0) val = (int'(mag_mem[rd_idx]) * int'(cfg_maxval)) / peak;
      if (val > cfg_maxval) val = cfg_maxval;
      if (cfg_invert) val = cfg_maxval - val;
      r.out_pixel = val[7:0];
      r.last = (rd_idx + 1 == total);
      if (r.last) restart_frame();
      else rd_idx++;
      return r;
   endfunction

   always @(posedge clock) begin
      edge_rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked++;
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected item: pixel %0d last %0b not_ready %0b",
                                       rsp_out_pixel, rsp_last, rsp_not_ready);
         end else begin
            exp_r = pending_pixels.pop_front();
            if (rsp_out_pixel !== exp_r.out_pixel || rsp_last !== exp_r.last ||
                rsp_not_ready !== exp_r.not_ready) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected pixel %0d last %0b not_ready %0b, got %0d %0b %0b",
                           exp_r.out_pixel, exp_r.last, exp_r.not_ready,
                           rsp_out_pixel, rsp_last, rsp_not_ready);
            end
         end
      end
   end

   task automatic send_req(logic kind, logic [7:0] px);
      req_valid <= 1'b1;
      req_type <= kind;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_LOAD) begin
         edge_load(px);
         loads_sent++;
      end else begin
         pending_pixels.push_back(edge_read());
         reads_sent++;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [8:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WIDTH: begin
            cfg_width = data;
            restart_frame();
         end
         CSR_HEIGHT: begin
            cfg_height = data;
            restart_frame();
         end
         CSR_MAXVAL: cfg_maxval = data[7:0];
         CSR_INVERT: cfg_invert = data[0];
         default: ;
      endcase
   endtask

   function automatic logic [7:0] rand_pixel();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // loads a frame then reads it back, with stray reads and loads mixed in
   task automatic run_frame(int noise_pct);
      int n;
      n = clamp_size(cfg_width) * clamp_size(cfg_height);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) send_req(REQ_READ, 8'($urandom));
         send_req(REQ_LOAD, rand_pixel());
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) send_req(REQ_LOAD, 8'($urandom));
         send_req(REQ_READ, 8'($urandom));
      end
   endtask

   task automatic test_early_reads();
      send_req(REQ_READ, 8'hff);
      send_req(REQ_READ, 8'h00);
      send_req(REQ_LOAD, 8'd7);
      send_req(REQ_READ, 8'h5a);
   endtask

   task automatic test_small_frames();
      logic [7:0] spot [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0};
      csr_write(CSR_WIDTH, 9'd3);
      csr_write(CSR_HEIGHT, 9'd3);
      for (int i = 0; i < 9; i++) send_req(REQ_LOAD, spot[i]);
      send_req(REQ_LOAD, 8'd99);
      for (int i = 0; i < 9; i++) send_req(REQ_READ, 8'd0);
      // flat frame, zero peak, inverted
      csr_write(CSR_INVERT, 9'd1);
      for (int i = 0; i < 9; i++) send_req(REQ_LOAD, 8'd200);
      for (int i = 0; i < 9; i++) send_req(REQ_READ, 8'd0);
      csr_write(CSR_MAXVAL, 9'd0);
      run_frame(0);
      csr_write(CSR_MAXVAL, 9'd1);
      run_frame(0);
      csr_write(CSR_INVERT, 9'd0);
      csr_write(CSR_MAXVAL, 9'd255);
   endtask

   task automatic test_size_limits();
      csr_write(CSR_WIDTH, 9'd1);
      csr_write(CSR_HEIGHT, 9'd0);
      run_frame(0);
      csr_write(CSR_WIDTH, 9'd2);
      csr_write(CSR_HEIGHT, 9'd2);
      run_frame(0);
   endtask

   task automatic test_restart();
      csr_write(CSR_WIDTH, 9'd4);
      csr_write(CSR_HEIGHT, 9'd5);
      for (int i = 0; i < 11; i++) send_req(REQ_LOAD, rand_pixel());
      csr_write(CSR_HEIGHT, 9'd4);
      send_req(REQ_READ, 8'd0);
      run_frame(5);
   endtask

   task automatic test_random(int idle, int stall, int frames);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int f = 0; f < frames; f++) begin
         csr_write(CSR_WIDTH, ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(3, 8)));
         csr_write(CSR_HEIGHT, 9'($urandom_range(3, 7)));
         csr_write(CSR_MAXVAL, 9'($urandom_range(255)));
         csr_write(CSR_INVERT, 9'($urandom_range(1)));
         if (clamp_size(cfg_width) > 16) csr_write(CSR_WIDTH, 9'($urandom_range(3, 8)));
         if ($urandom_range(5) == 0) begin
            for (int i = 0; i < 7; i++) send_req(REQ_LOAD, rand_pixel());
            send_req(REQ_READ, 8'd0);
            continue;
         end
         run_frame(6);
         if (f == 1) drain();
      end
   endtask

   initial begin
      errors = 0;
      checked = 0;
      loads_sent = 0;
      reads_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_type <= REQ_LOAD;
      req_pixel <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_WIDTH;
      csr_data <= '0;
      rsp_stall <= 1'b0;
      foreach (row_pixels[i]) row_pixels[i] = '0;
      foreach (mag_mem[i]) mag_mem[i] = '0;
      restart_frame();
      cfg_width = 9'd256;
      cfg_height = 9'd256;
      cfg_maxval = 8'd255;
      cfg_invert = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_early_reads();
      test_small_frames();
      test_restart();
      test_size_limits();
      test_random(0, 0, 4);
      test_random(51, 0, 4);
      test_random(0, 51, 4);
      test_random(32, 32, 4);
      drain();

      $display("covered %0d loads and %0d reads, %0d items checked, including",
               loads_sent, reads_sent, checked);
      $display("early reads, restarts, size clamping, zero peak and inverted output");
      if (errors == 0) begin
         $display("laplacian_edge_normalize_tb: clean");
      end else begin
         $display("laplacian_edge_normalize_tb: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lenorm_pkg.sv
rtl/lenorm_ram.sv
rtl/laplacian_edge_normalize.sv
rtl/lenorm_chk.sv
tb/sv/laplacian_edge_normalize_tb.sv
